### hw/rtl/assert_macros.svh
// Assertion macros for the top RTL file of the tile accumulator.
// Define NO_ASSERTIONS to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check that a property holds at every rising edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that the consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

### hw/rtl/mmt_pkg.sv
package mmt_pkg;

    // Tile geometry and data widths.
    localparam int TILE_DIM = 4;
    localparam int NUM_ACC  = TILE_DIM * TILE_DIM;
    localparam int DATA_W   = 32;
    localparam int COORD_W  = 2;
    localparam int IDX_W    = 2 * COORD_W;

    // Default depth of the request queue between front and back.
    localparam int Q_DEPTH = 4;

    // One k step as it travels from the queue to the multiply lanes.
    typedef struct packed {
        logic [TILE_DIM-1:0][DATA_W-1:0] a;
        logic [TILE_DIM-1:0][DATA_W-1:0] b;
        logic                            first_step;
        logic                            last_step;
    } t_step;

    // Finished tile handed from the accumulators to the output stage.
    typedef struct packed {
        logic                           load;
        logic [NUM_ACC-1:0][DATA_W-1:0] sums;
    } t_snap;

endpackage

### hw/rtl/mmt_if.sv
// Channel carrying one k step request.
interface mmt_step_if;
    logic                        valid;
    logic                        ready;
    logic [mmt_pkg::DATA_W-1:0]  a_row0;
    logic [mmt_pkg::DATA_W-1:0]  a_row1;
    logic [mmt_pkg::DATA_W-1:0]  a_row2;
    logic [mmt_pkg::DATA_W-1:0]  a_row3;
    logic [mmt_pkg::DATA_W-1:0]  b_col0;
    logic [mmt_pkg::DATA_W-1:0]  b_col1;
    logic [mmt_pkg::DATA_W-1:0]  b_col2;
    logic [mmt_pkg::DATA_W-1:0]  b_col3;
    logic                        first_step;
    logic                        last_step;

    modport source (
        output valid, a_row0, a_row1, a_row2, a_row3,
        output b_col0, b_col1, b_col2, b_col3, first_step, last_step,
        input  ready
    );
    modport sink (
        input  valid, a_row0, a_row1, a_row2, a_row3,
        input  b_col0, b_col1, b_col2, b_col3, first_step, last_step,
        output ready
    );
endinterface

// Channel carrying one finished tile element.
interface mmt_result_if;
    logic                        valid;
    logic                        ready;
    logic [mmt_pkg::COORD_W-1:0] tile_row;
    logic [mmt_pkg::COORD_W-1:0] tile_col;
    logic [mmt_pkg::DATA_W-1:0]  sum_value;
    logic                        run_end;

    modport source (
        output valid, tile_row, tile_col, sum_value, run_end,
        input  ready
    );
    modport sink (
        input  valid, tile_row, tile_col, sum_value, run_end,
        output ready
    );
endinterface

### hw/rtl/mmt_front.sv
module mmt_front #(
    parameter int QUEUE_DEPTH = mmt_pkg::Q_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    mmt_step_if.sink       i_step,
    output mmt_pkg::t_step o_item,
    output logic           o_item_valid,
    input  logic           i_item_pop
);
    import mmt_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_step            r_queue [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             w_push;
    logic             w_pop;
    t_step            w_item;

    // Gather the request fields into one queue entry.
    always_comb begin
        w_item.a[0]       = i_step.a_row0;
        w_item.a[1]       = i_step.a_row1;
        w_item.a[2]       = i_step.a_row2;
        w_item.a[3]       = i_step.a_row3;
        w_item.b[0]       = i_step.b_col0;
        w_item.b[1]       = i_step.b_col1;
        w_item.b[2]       = i_step.b_col2;
        w_item.b[3]       = i_step.b_col3;
        w_item.first_step = i_step.first_step;
        w_item.last_step  = i_step.last_step;
    end

    // The queue takes a request whenever it has a free slot.
    assign i_step.ready = (r_count != CNT_W'(QUEUE_DEPTH));
    assign w_push       = i_step.valid && i_step.ready;
    assign w_pop        = i_item_pop && o_item_valid;
    assign o_item_valid = (r_count != '0);
    assign o_item       = r_queue[r_rd_ptr];

    // Pointer and fill count update.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_queue[r_wr_ptr] <= w_item;
        end
    end

endmodule

### hw/rtl/mmt_mac.sv
module mmt_mac (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  mmt_pkg::t_step i_item,
    input  logic           i_item_valid,
    output logic           o_item_pop,
    input  logic           i_snap_free,
    output mmt_pkg::t_snap o_snap
);
    import mmt_pkg::*;

    logic                           r_m_valid;
    logic                           n_m_valid;
    logic                           r_m_first;
    logic                           r_m_last;
    logic [NUM_ACC-1:0][DATA_W-1:0] r_m_prod;
    logic [NUM_ACC-1:0][DATA_W-1:0] n_m_prod;
    logic [NUM_ACC-1:0][DATA_W-1:0] r_acc;
    logic [NUM_ACC-1:0][DATA_W-1:0] n_acc;
    logic                           w_acc_go;
    logic                           w_m_take;

    // A step in the product register may retire unless it ends a tile while the
    // output stage still holds the previous one.
    assign w_acc_go   = r_m_valid && (!r_m_last || i_snap_free);
    assign w_m_take   = i_item_valid && (!r_m_valid || w_acc_go);
    assign o_item_pop = w_m_take;

    // Sixteen multiply lanes, low 32 bits of each product.
    always_comb begin
        for (int r = 0; r < TILE_DIM; r++) begin
            for (int c = 0; c < TILE_DIM; c++) begin
                n_m_prod[r * TILE_DIM + c] = i_item.a[r] * i_item.b[c];
            end
        end
    end

    // Accumulate, starting from zero on the first step of a run.
    always_comb begin
        for (int k = 0; k < NUM_ACC; k++) begin
            n_acc[k] = (r_m_first ? '0 : r_acc[k]) + r_m_prod[k];
        end
    end

    assign o_snap.load = w_acc_go && r_m_last;
    assign o_snap.sums = n_acc;

    // Product stage occupancy.
    always_comb begin
        n_m_valid = r_m_valid;
        if (w_m_take) begin
            n_m_valid = 1'b1;
        end else if (w_acc_go) begin
            n_m_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else begin
            r_m_valid <= n_m_valid;
        end
    end

    // Product register.
    always_ff @(posedge i_clk) begin
        if (w_m_take) begin
            r_m_prod  <= n_m_prod;
            r_m_first <= i_item.first_step;
            r_m_last  <= i_item.last_step;
        end
    end

    // Accumulators are zero after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (w_acc_go) begin
            r_acc <= n_acc;
        end
    end

endmodule

### hw/rtl/mmt_drain.sv
module mmt_drain (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  mmt_pkg::t_snap i_snap,
    output logic           o_snap_free,
    mmt_result_if.source   o_res
);
    import mmt_pkg::*;

    logic [NUM_ACC-1:0][DATA_W-1:0] r_buf;
    logic [IDX_W-1:0]               r_idx;
    logic [IDX_W-1:0]               n_idx;
    logic                           r_busy;
    logic                           n_busy;
    logic                           w_fire;
    logic                           w_done;

    assign w_fire      = o_res.valid && o_res.ready;
    assign w_done      = w_fire && (r_idx == IDX_W'(NUM_ACC - 1));
    assign o_snap_free = !r_busy || w_done;

    // Present the held tile in row-major order.
    assign o_res.valid     = r_busy;
    assign o_res.tile_row  = r_idx[IDX_W-1:COORD_W];
    assign o_res.tile_col  = r_idx[COORD_W-1:0];
    assign o_res.sum_value = r_buf[r_idx];
    assign o_res.run_end   = (r_idx == IDX_W'(NUM_ACC - 1));

    // Element counter and busy flag.
    always_comb begin
        n_idx  = r_idx;
        n_busy = r_busy;
        if (i_snap.load) begin
            n_idx  = '0;
            n_busy = 1'b1;
        end else if (w_done) begin
            n_idx  = '0;
            n_busy = 1'b0;
        end else if (w_fire) begin
            n_idx = r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_busy <= 1'b0;
        end else begin
            r_idx  <= n_idx;
            r_busy <= n_busy;
        end
    end

    // Output buffer holds a finished tile while it drains.
    always_ff @(posedge i_clk) begin
        if (i_snap.load) begin
            r_buf <= i_snap.sums;
        end
    end

endmodule

### hw/rtl/int_matmul_tile_4x4.sv
// 4x4 integer outer-product tile accumulator for C = A * transpose(B).
// Input channel i_step: one request per k step with four A elements (a_row0..3),
// four B elements (b_col0..3) and the first_step / last_step marks. Every
// accumulator (r, c) gains a_row[r] * b_col[c], unsigned, modulo 2^32; first_step
// clears all sixteen sums before the products of that step are added.
// Output channel o_res: after a request with last_step, sixteen results in
// row-major order, each with tile_row, tile_col, sum_value and run_end on the last.
// Throughput: one request per cycle, set by the sixteen parallel multiply lanes.
// A tile leaves one element at a time through the output port, so a
// following last_step request waits in the product register until the output
// buffer frees; requests in between keep accumulating meanwhile.
// A request passes through its queue entry, the product register and then the
// accumulators; a tile's sums load into the output buffer as its last request retires.
// Reset empties the request queue and the pipeline and clears all accumulators to zero.
// When the receiver stalls, the current result holds; behind a waiting last_step
// request, the request queue (QUEUE_DEPTH entries) fills before i_step.ready drops.
module int_matmul_tile_4x4 #(
    parameter int QUEUE_DEPTH = mmt_pkg::Q_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mmt_step_if.sink      i_step,
    mmt_result_if.source  o_res
);
    import mmt_pkg::*;

    `include "assert_macros.svh"

    t_step w_item;
    logic  w_item_valid;
    logic  w_item_pop;
    t_snap w_snap;
    logic  w_snap_free;
    logic  w_res_mid;

    // Front: request queue.
    mmt_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (i_step),
        .o_item       (w_item),
        .o_item_valid (w_item_valid),
        .i_item_pop   (w_item_pop)
    );

    // Back: multiply lanes and accumulators.
    mmt_mac u_mac (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (w_item),
        .i_item_valid (w_item_valid),
        .o_item_pop   (w_item_pop),
        .i_snap_free  (w_snap_free),
        .o_snap       (w_snap)
    );

    // Back: output buffer and result sequencing.
    mmt_drain u_drain (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_snap      (w_snap),
        .o_snap_free (w_snap_free),
        .o_res       (o_res)
    );

    // A result other than the last of its tile has just been taken.
    assign w_res_mid = o_res.valid && o_res.ready && !o_res.run_end;

    // A finished tile is only handed over when the output buffer can take it.
    `ASSERT_IMPL(a_snap_free, i_clk, i_rst_n, w_snap.load, w_snap_free, "output buffer busy")
    // The queue is only popped while it holds a request.
    `ASSERT_IMPL(a_pop_valid, i_clk, i_rst_n, w_item_pop, w_item_valid, "pop from empty queue")
    // Results of one tile leave without gaps once one has been taken.
    `ASSERT_NEXT(a_tile_cont, i_clk, i_rst_n, w_res_mid, o_res.valid, "tile output broke off")

endmodule

### bench/tb_int_matmul_tile_4x4.sv
`timescale 1ns / 100ps

module tb_int_matmul_tile_4x4;

    import mmt_pkg::*;

    typedef logic [DATA_W-1:0] t_word;

    // One finished tile element as it leaves the block.
    typedef struct {
        logic [COORD_W-1:0] tile_row;
        logic [COORD_W-1:0] tile_col;
        t_word              sum_value;
        logic               run_end;
    } t_tile_elem;

    // Cycles to let the three-stage pipeline settle once nothing is pending.
    localparam int SETTLE_CYCLES = 8;
    // Requests in each random phase.
    localparam int PHASE_STEPS = 95;

    // Tracks the sixteen running sums and the tile elements still owed by the block.
    class tile_sum_tracker;
        t_word      tile_acc [NUM_ACC];
        t_tile_elem owed_elems [$];
        int         mismatches;
        int         elems_checked;
        int         tiles_closed;

        function new();
            foreach (tile_acc[i]) tile_acc[i] = '0;
            mismatches    = 0;
            elems_checked = 0;
            tiles_closed  = 0;
        endfunction

        // Accumulate one accepted k step; a last step queues the whole tile.
        function void note_step(t_step req);
            t_word      prod;
            t_tile_elem elem;
            if (req.first_step) begin
                foreach (tile_acc[i]) tile_acc[i] = '0;
            end
            for (int r = 0; r < TILE_DIM; r++) begin
                for (int c = 0; c < TILE_DIM; c++) begin
                    prod = req.a[r] * req.b[c];
                    tile_acc[r * TILE_DIM + c] = tile_acc[r * TILE_DIM + c] + prod;
                end
            end
            if (req.last_step) begin
                tiles_closed++;
                for (int k = 0; k < NUM_ACC; k++) begin
                    elem.tile_row  = COORD_W'(k / TILE_DIM);
                    elem.tile_col  = COORD_W'(k % TILE_DIM);
                    elem.sum_value = tile_acc[k];
                    elem.run_end   = (k == NUM_ACC - 1);
                    owed_elems.push_back(elem);
                end
            end
        endfunction

        // Compare one accepted result with the oldest owed element.
        function void check_result(t_tile_elem got);
            t_tile_elem want;
            if (owed_elems.size() == 0) begin
                $error("unexpected result: tile_row %0d tile_col %0d sum_value 0x%08h",
                       got.tile_row, got.tile_col, got.sum_value);
                mismatches++;
                return;
            end
            want = owed_elems.pop_front();
            elems_checked++;
            if (got.tile_row !== want.tile_row) begin
                $error("tile_row: expected %0d, got %0d", want.tile_row, got.tile_row);
                mismatches++;
            end
            if (got.tile_col !== want.tile_col) begin
                $error("tile_col: expected %0d, got %0d", want.tile_col, got.tile_col);
                mismatches++;
            end
            if (got.sum_value !== want.sum_value) begin
                $error("sum_value: expected 0x%08h, got 0x%08h", want.sum_value, got.sum_value);
                mismatches++;
            end
            if (got.run_end !== want.run_end) begin
                $error("run_end: expected %0d, got %0d", want.run_end, got.run_end);
                mismatches++;
            end
        endfunction

        function int owed();
            return owed_elems.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    mmt_step_if   step_ch ();
    mmt_result_if res_ch ();

    int_matmul_tile_4x4 dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step_ch),
        .o_res   (res_ch)
    );

    tile_sum_tracker tracker = new();

    int         send_idle_pct;
    int         take_stall_pct;
    int         steps_sent;
    t_step      seen_req;
    t_tile_elem taken;

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Run limit.
    initial begin
        #1_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Receiver stalls at random, at the rate of the current phase.
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            res_ch.ready <= ($urandom_range(99) >= take_stall_pct);
        end
    end

    // Feed every accepted request to the tracker.
    always @(posedge i_clk) begin
        if (i_rst_n && step_ch.valid && step_ch.ready) begin
            seen_req.a[0]      = step_ch.a_row0;
            seen_req.a[1]      = step_ch.a_row1;
            seen_req.a[2]      = step_ch.a_row2;
            seen_req.a[3]      = step_ch.a_row3;
            seen_req.b[0]      = step_ch.b_col0;
            seen_req.b[1]      = step_ch.b_col1;
            seen_req.b[2]      = step_ch.b_col2;
            seen_req.b[3]      = step_ch.b_col3;
            seen_req.first_step = step_ch.first_step;
            seen_req.last_step  = step_ch.last_step;
            tracker.note_step(seen_req);
        end
    end

    // Check every accepted result.
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            taken.tile_row  = res_ch.tile_row;
            taken.tile_col  = res_ch.tile_col;
            taken.sum_value = res_ch.sum_value;
            taken.run_end   = res_ch.run_end;
            tracker.check_result(taken);
        end
    end

    function automatic t_step build_step(t_word a0, t_word a1, t_word a2, t_word a3,
                                         t_word b0, t_word b1, t_word b2, t_word b3,
                                         logic first, logic last);
        t_step req;
        req.a[0] = a0;
        req.a[1] = a1;
        req.a[2] = a2;
        req.a[3] = a3;
        req.b[0] = b0;
        req.b[1] = b1;
        req.b[2] = b2;
        req.b[3] = b3;
        req.first_step = first;
        req.last_step  = last;
        return req;
    endfunction

    // Operand mix: extremes, single bits, small values and full random words.
    function automatic t_word rand_word();
        unique case ($urandom_range(0, 6))
            0: return '0;
            1: return '1;
            2: return t_word'(1) << $urandom_range(0, DATA_W - 1);
            3: return t_word'($urandom_range(0, 15));
            4: return ~t_word'($urandom_range(0, 15));
            default: return t_word'($urandom());
        endcase
    endfunction

    function automatic t_step rand_step(logic first, logic last);
        return build_step(rand_word(), rand_word(), rand_word(), rand_word(),
                          rand_word(), rand_word(), rand_word(), rand_word(), first, last);
    endfunction

    // Drive one request, called and returning at a falling edge.
    task automatic send_step(t_step req);
        while ($urandom_range(99) < send_idle_pct) begin
            step_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        step_ch.valid      <= 1'b1;
        step_ch.a_row0     <= req.a[0];
        step_ch.a_row1     <= req.a[1];
        step_ch.a_row2     <= req.a[2];
        step_ch.a_row3     <= req.a[3];
        step_ch.b_col0     <= req.b[0];
        step_ch.b_col1     <= req.b[1];
        step_ch.b_col2     <= req.b[2];
        step_ch.b_col3     <= req.b[3];
        step_ch.first_step <= req.first_step;
        step_ch.last_step  <= req.last_step;
        @(posedge i_clk);
        while (!step_ch.ready) @(posedge i_clk);
        steps_sent++;
        @(negedge i_clk);
    endtask

    // Hold off the sender until every owed result has come back.
    task automatic wait_for_drain();
        step_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (tracker.owed() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic run_directed();
        // Accumulation straight after reset, with no first mark.
        send_step(build_step('1, '1, '1, '1, '1, '1, '1, '1, 1'b0, 1'b0));
        // Products and sums that wrap past 32 bits.
        send_step(build_step(32'h8000_0000, 32'hFFFF_FFFF, 32'h0001_0000, 32'h1234_5678,
                             32'h0000_0002, 32'h0001_0000, 32'hFFFF_FFFF, 32'h8765_4321,
                             1'b0, 1'b1));
        // Sums carry on past an emitted tile when no first mark comes.
        send_step(build_step(1, 2, 3, 4, 5, 6, 7, 8, 1'b0, 1'b1));
        // First and last on one request.
        send_step(build_step('1, '1, '1, '1, '1, '1, '1, '1, 1'b1, 1'b1));
        send_step(build_step('0, '0, '0, '0, '0, '0, '0, '0, 1'b1, 1'b1));
        // Single-step tiles back to back against the output buffer.
        for (int i = 0; i < 3; i++) begin
            send_step(build_step(32'hAAAA_AAAA, 32'h5555_5555, t_word'(i), '1,
                                 32'h5555_5555, 32'hAAAA_AAAA, '1, t_word'(i + 7),
                                 1'b1, 1'b1));
        end
        // A longer tile with walking ones in the operands.
        send_step(build_step(1, 2, 4, 8, 16, 32, 64, 128, 1'b1, 1'b0));
        for (int i = 0; i < 6; i++) begin
            send_step(build_step(t_word'(1) << (i * 5), t_word'(1) << (i * 5 + 1),
                                 t_word'(1) << (i * 5 + 2), t_word'(1) << (31 - i),
                                 t_word'(1) << (i * 4), t_word'(3) << (i * 4 + 1),
                                 '1, ~(t_word'(1) << i), 1'b0, 1'b0));
        end
        send_step(build_step(32'hDEAD_BEEF, 32'hCAFE_F00D, 32'h0BAD_C0DE, 32'hFEED_FACE,
                             32'h1357_9BDF, 32'h2468_ACE0, 32'hFFFF_0000, 32'h0000_FFFF,
                             1'b0, 1'b1));
    endtask

    // Mostly whole tiles with random depth; some cut short, some stray requests.
    task automatic run_random(int stop_at);
        int shape;
        int depth;
        while (steps_sent < stop_at) begin
            shape = $urandom_range(99);
            depth = $urandom_range(0, 6);
            if (shape < 75) begin
                send_step(rand_step(1'b1, depth == 0));
                for (int i = 1; i < depth; i++) send_step(rand_step(1'b0, 1'b0));
                if (depth > 0) send_step(rand_step(1'b0, 1'b1));
            end else if (shape < 85) begin
                send_step(rand_step(1'b1, 1'b0));
                for (int i = 0; i < depth; i++) send_step(rand_step(1'b0, 1'b0));
            end else begin
                send_step(rand_step(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
            end
        end
    endtask

    initial begin
        int sender_idle [4];
        int receiver_stall [4];
        sender_idle    = '{0, 75, 0, 12};
        receiver_stall = '{0, 0, 75, 12};
        i_rst_n            = 1'b0;
        step_ch.valid      = 1'b0;
        step_ch.a_row0     = '0;
        step_ch.a_row1     = '0;
        step_ch.a_row2     = '0;
        step_ch.a_row3     = '0;
        step_ch.b_col0     = '0;
        step_ch.b_col1     = '0;
        step_ch.b_col2     = '0;
        step_ch.b_col3     = '0;
        step_ch.first_step = 1'b0;
        step_ch.last_step  = 1'b0;
        send_idle_pct      = 0;
        take_stall_pct     = 0;
        steps_sent         = 0;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        run_directed();
        wait_for_drain();

        // Random phases: no idling, idle sender, stalling receiver, both.
        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = sender_idle[p];
            take_stall_pct = receiver_stall[p];
            run_random(steps_sent + PHASE_STEPS);
            wait_for_drain();
        end

        if (tracker.owed() != 0) begin
            $error("results never returned: %0d", tracker.owed());
        end
        $display("Run covered %0d k-step requests closing %0d tiles, %0d tile elements checked,",
                 steps_sent, tracker.tiles_closed, tracker.elems_checked);
        $display("over four idle/stall mixes on both channels; %0d mismatches.",
                 tracker.mismatches);
        if (tracker.mismatches == 0 && tracker.owed() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/mmt_pkg.sv
hw/rtl/mmt_if.sv
hw/rtl/mmt_front.sv
hw/rtl/mmt_mac.sv
hw/rtl/mmt_drain.sv
hw/rtl/int_matmul_tile_4x4.sv
bench/tb_int_matmul_tile_4x4.sv
